@@ rtl/srdm_pkg.sv @@
// Shared types and constants of the sensor retry/degrade monitor.
package srdm_pkg;

    // Item kinds on the input channel.
    typedef enum logic [1:0] {
        KIND_READ     = 2'd0,
        KIND_ISSUE    = 2'd1,
        KIND_WATCHDOG = 2'd2,
        KIND_UNUSED   = 2'd3
    } t_kind;

    // Event status codes of a read result.
    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_IO_ERROR     = 3'd1,
        ST_BAD_ARGUMENT = 3'd2,
        ST_RETRYING     = 3'd3,
        ST_DEGRADED     = 3'd4,
        ST_RECOVERED    = 3'd5
    } t_status;

    // Configuration register indexes.
    localparam logic [2:0] CFG_SENSOR_COUNT     = 3'd0;
    localparam logic [2:0] CFG_RETRY_LIMIT      = 3'd1;
    localparam logic [2:0] CFG_RETRY_BACKOFF    = 3'd2;
    localparam logic [2:0] CFG_DEGRADED_BACKOFF = 3'd3;
    localparam logic [2:0] CFG_WATCHDOG_GRACE   = 3'd4;
    localparam logic [2:0] CFG_FAULT_PERIOD     = 3'd5;

    // Error codes carried in a reading.
    localparam logic [31:0] CODE_BAD_ARGUMENT = 32'hFFFF_FFEA;  // -22
    localparam logic [7:0]  RUN_MAX           = 8'd255;

    // Shared arithmetic unit operations.
    typedef enum logic [1:0] {
        ALU_ADD = 2'd0,
        ALU_SUB = 2'd1,
        ALU_GE  = 2'd2
    } t_alu_op;

    typedef struct packed {
        t_alu_op     op;
        logic [31:0] a;
        logic [31:0] b;
    } t_alu_req;

    typedef struct packed {
        logic [31:0] res;  // a+b or a-b
        logic        ge;   // a >= b, unsigned
    } t_alu_rsp;

endpackage

@@ rtl/srdm_alu.sv @@
// Shared 32-bit add/subtract/compare unit of the monitor.
module srdm_alu (
    input  srdm_pkg::t_alu_req i_req,
    output srdm_pkg::t_alu_rsp o_rsp
);

    logic        sub;
    logic [32:0] sum;

    always_comb begin
        unique case (i_req.op)
            srdm_pkg::ALU_ADD: sub = 1'b0;
            srdm_pkg::ALU_SUB: sub = 1'b1;
            srdm_pkg::ALU_GE:  sub = 1'b1;
            default:           sub = 1'b0;
        endcase
    end

    // a + ~b + 1 for subtract; carry out set means no borrow
    assign sum = {1'b0, i_req.a} + {1'b0, (sub ? ~i_req.b : i_req.b)} + {32'd0, sub};

    assign o_rsp.res = sum[31:0];
    assign o_rsp.ge  = sub & sum[32];

endmodule

@@ rtl/sensor_retry_degrade_monitor.sv @@
// Top level of the per-sensor retry/degrade health monitor.
//
// Usage:
//  Input channel (i_in_valid / o_in_stall) carries one item: kind, sensor id,
//  signed reading and a millisecond timestamp. A transfer happens at a clock
//  edge with valid high and stall low. Kinds: read result, issue query,
//  watchdog query. Each item gives exactly one result on the output channel
//  (o_out_valid / i_out_stall), held stable while the receiver stalls.
//  Configuration writes go through i_cfg_valid / o_cfg_ready with a register
//  index and data; ready is always high and writes are expected only while
//  the block is idle.
//  Sequencing: items are worked one at a time by a small sequencer
//  around one shared 32-bit add/compare unit. A read passes the load,
//  phase, evaluate and write steps to the output register, an issue query
//  load and issue, a watchdog query scan and compare per active sensor.
//  The input stalls while an item is in work; the next item may be taken
//  while a finished result still waits in the output register.
//  A stalled output only holds the sequencer in its final step until the
//  output register frees up.
//  Reset (synchronous, active low) restores the register defaults and
//  clears every sensor entry to zero.
module sensor_retry_degrade_monitor #(
    parameter int MAX_SENSORS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // item input
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_sensor_num,
    input  logic signed [31:0] i_reading_value,
    input  logic [31:0] i_time_ms,
    // result output
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_event_status,
    output logic        o_fault_injected,
    output logic        o_may_issue,
    output logic        o_withhold_feed,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int IDX_W = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
    localparam int CNT_W = $clog2(MAX_SENSORS + 1);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_LOAD  = 9'b000000010,
        S_PHASE = 9'b000000100,
        S_EVAL  = 9'b000001000,
        S_WRITE = 9'b000010000,
        S_ISSUE = 9'b000100000,
        S_SCAN  = 9'b001000000,
        S_CMP   = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [3:0]  r_sensor_count;
    logic [3:0]  r_retry_limit;
    logic [15:0] r_retry_backoff;
    logic [15:0] r_degraded_backoff;
    logic [31:0] r_watchdog_grace;
    logic [7:0]  r_fault_period;

    // per-sensor entries
    logic [7:0]  r_error_run [MAX_SENSORS];
    logic        r_degraded  [MAX_SENSORS];
    logic [31:0] r_deadline  [MAX_SENSORS];
    logic [31:0] r_dstart    [MAX_SENSORS];
    logic [7:0]  r_phase_cnt [MAX_SENSORS];

    // item in work
    srdm_pkg::t_kind r_kind;
    logic [31:0] r_value;
    logic [31:0] r_time;
    logic        r_known;
    logic [IDX_W-1:0] r_idx;

    // working copy of an entry
    logic [7:0]  r_run;
    logic        r_flag;
    logic [31:0] r_dl;
    logic [7:0]  r_ph;
    logic        r_inject;
    logic        r_retry;
    logic [31:0] r_elapsed;
    logic [CNT_W-1:0] r_scan;

    // result being built
    srdm_pkg::t_status r_res_status;
    logic        r_res_may;
    logic        r_res_withhold;

    // output register
    logic        r_out_valid;
    logic [2:0]  r_o_status;
    logic        r_o_inject;
    logic        r_o_may;
    logic        r_o_withhold;

    srdm_pkg::t_alu_req alu_req;
    srdm_pkg::t_alu_rsp alu_rsp;

    logic [7:0] active;
    logic       in_xfer;
    logic       out_free;
    logic [8:0] ph_next;
    logic       eff_neg;
    logic       eff_bad;
    logic [7:0] run_next;
    logic       scan_end;
    logic [IDX_W-1:0] ent;

    srdm_alu u_alu (
        .i_req(alu_req),
        .o_rsp(alu_rsp)
    );

    // sensor count above the entry count acts as the entry count
    assign active = ({4'd0, r_sensor_count} > 8'(MAX_SENSORS)) ? 8'(MAX_SENSORS)
                                                              : {4'd0, r_sensor_count};
    assign in_xfer  = i_in_valid & ~o_in_stall;
    assign out_free = ~r_out_valid | ~i_out_stall;
    assign ph_next  = {1'b0, r_ph} + 9'd1;
    // an injected fault reads as a negative reading, never as a bad argument
    assign eff_neg  = r_inject | r_value[31];
    assign eff_bad  = ~r_inject & (r_value == srdm_pkg::CODE_BAD_ARGUMENT);
    assign run_next = (r_run == srdm_pkg::RUN_MAX) ? r_run : r_run + 8'd1;
    assign scan_end = 8'(r_scan) >= active;
    assign ent      = (r_state == S_SCAN) ? r_scan[IDX_W-1:0] : r_idx;

    // shared unit operand selection
    always_comb begin
        alu_req.op = srdm_pkg::ALU_GE;
        alu_req.a  = r_time;
        alu_req.b  = r_dl;
        unique case (r_state)
            S_PHASE: begin
                alu_req.a = {23'd0, ph_next};
                alu_req.b = {24'd0, r_fault_period};
            end
            S_WRITE: begin
                alu_req.op = srdm_pkg::ALU_ADD;
                alu_req.b  = r_retry ? {16'd0, r_retry_backoff} : {16'd0, r_degraded_backoff};
            end
            S_SCAN: begin
                alu_req.op = srdm_pkg::ALU_SUB;
                alu_req.b  = r_dstart[ent];
            end
            S_CMP: begin
                alu_req.a = r_elapsed;
                alu_req.b = r_watchdog_grace;
            end
            default: begin
                alu_req.b = r_dl;
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    unique case (srdm_pkg::t_kind'(i_kind))
                        srdm_pkg::KIND_WATCHDOG: n_state = S_SCAN;
                        srdm_pkg::KIND_UNUSED:   n_state = S_DONE;
                        default:                 n_state = S_LOAD;
                    endcase
                end
            end
            S_LOAD:  n_state = (r_kind == srdm_pkg::KIND_READ) ? S_PHASE : S_ISSUE;
            S_PHASE: n_state = S_EVAL;
            S_EVAL:  n_state = S_WRITE;
            S_WRITE: n_state = S_DONE;
            S_ISSUE: n_state = S_DONE;
            S_SCAN:  n_state = scan_end ? S_DONE : S_CMP;
            S_CMP:   n_state = (r_flag && alu_rsp.ge) ? S_DONE : S_SCAN;
            S_DONE:  n_state = out_free ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sensor_count     <= 4'd1;
            r_retry_limit      <= 4'd2;
            r_retry_backoff    <= 16'd200;
            r_degraded_backoff <= 16'd2000;
            r_watchdog_grace   <= 32'd10000;
            r_fault_period     <= 8'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                srdm_pkg::CFG_SENSOR_COUNT:     r_sensor_count     <= i_cfg_data[3:0];
                srdm_pkg::CFG_RETRY_LIMIT:      r_retry_limit      <= i_cfg_data[3:0];
                srdm_pkg::CFG_RETRY_BACKOFF:    r_retry_backoff    <= i_cfg_data[15:0];
                srdm_pkg::CFG_DEGRADED_BACKOFF: r_degraded_backoff <= i_cfg_data[15:0];
                srdm_pkg::CFG_WATCHDOG_GRACE:   r_watchdog_grace   <= i_cfg_data;
                srdm_pkg::CFG_FAULT_PERIOD:     r_fault_period     <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // item capture and working registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    r_kind  <= srdm_pkg::t_kind'(i_kind);
                    r_value <= i_reading_value;
                    r_time  <= i_time_ms;
                    r_known <= (i_sensor_num != 8'd0) && (i_sensor_num <= active);
                    r_idx   <= IDX_W'(i_sensor_num - 8'd1);
                    r_scan  <= '0;
                    r_inject       <= 1'b0;
                    r_res_may      <= 1'b0;
                    r_res_withhold <= 1'b0;
                    r_res_status   <= srdm_pkg::ST_OK;
                end
            end
            S_LOAD: begin
                r_run <= r_error_run[ent];
                r_flag <= r_degraded[ent];
                r_dl  <= r_deadline[ent];
                r_ph  <= r_phase_cnt[ent];
            end
            S_PHASE: begin
                r_inject <= r_known && (r_fault_period != 8'd0) && alu_rsp.ge;
            end
            S_EVAL: begin
                if (eff_neg) begin
                    r_run <= run_next;
                    if (!r_known) begin
                        r_res_status <= eff_bad ? srdm_pkg::ST_BAD_ARGUMENT
                                                : srdm_pkg::ST_IO_ERROR;
                    end else if ({4'd0, r_retry_limit} >= run_next) begin
                        r_res_status <= srdm_pkg::ST_RETRYING;
                        r_retry      <= 1'b1;
                    end else begin
                        r_res_status <= srdm_pkg::ST_DEGRADED;
                        r_retry      <= 1'b0;
                    end
                end else begin
                    r_res_status <= (r_known && r_flag) ? srdm_pkg::ST_RECOVERED
                                                        : srdm_pkg::ST_OK;
                end
            end
            S_ISSUE: begin
                r_res_may <= r_known && alu_rsp.ge;
            end
            S_SCAN: begin
                r_elapsed <= alu_rsp.res;
                r_flag    <= r_degraded[ent];
            end
            S_CMP: begin
                if (r_flag && alu_rsp.ge) begin
                    r_res_withhold <= 1'b1;
                end
                r_scan <= r_scan + CNT_W'(1);
            end
            default: ;
        endcase
    end

    // sensor entries
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_SENSORS; k++) begin
                r_error_run[k] <= 8'd0;
                r_degraded[k]  <= 1'b0;
                r_deadline[k]  <= 32'd0;
                r_dstart[k]    <= 32'd0;
                r_phase_cnt[k] <= 8'd0;
            end
        end else if (r_known && r_kind == srdm_pkg::KIND_READ) begin
            if (r_state == S_PHASE && r_fault_period != 8'd0) begin
                r_phase_cnt[ent] <= alu_rsp.ge ? 8'd0 : ph_next[7:0];
            end
            if (r_state == S_WRITE) begin
                if (eff_neg) begin
                    r_error_run[ent] <= r_run;
                    r_deadline[ent]  <= alu_rsp.res;
                    if (!r_retry) begin
                        if (!r_flag) begin
                            r_dstart[ent] <= r_time;
                        end
                        r_degraded[ent] <= 1'b1;
                    end
                end else begin
                    r_error_run[ent] <= 8'd0;
                    r_degraded[ent]  <= 1'b0;
                    r_deadline[ent]  <= 32'd0;
                    r_dstart[ent]    <= 32'd0;
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_o_status   <= (r_kind == srdm_pkg::KIND_READ) ? r_res_status : srdm_pkg::ST_OK;
            r_o_inject   <= (r_kind == srdm_pkg::KIND_READ) && r_inject;
            r_o_may      <= (r_kind == srdm_pkg::KIND_ISSUE) && r_res_may;
            r_o_withhold <= (r_kind == srdm_pkg::KIND_WATCHDOG) && r_res_withhold;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_event_status   = r_o_status;
    assign o_fault_injected = r_o_inject;
    assign o_may_issue      = r_o_may;
    assign o_withhold_feed  = r_o_withhold;

    // the input closes for the item just taken
    a_stall_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> o_in_stall)
        else $error("input open right after a transfer");

    // the scan index never exceeds the entry count
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN || r_state == S_CMP) |-> (8'(r_scan) <= 8'(MAX_SENSORS)))
        else $error("watchdog scan out of range");

    // an injected fault is always counted against a known sensor
    a_inject_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_o_inject) |->
            (r_o_status == srdm_pkg::ST_RETRYING || r_o_status == srdm_pkg::ST_DEGRADED))
        else $error("injected fault without retry or degrade status");

    // a finished result is not dropped while the output stalls
    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && i_out_stall) |=> (r_state == S_DONE))
        else $error("result left the sequencer while output stalled");

endmodule
